/* rtl/core/stbs_pkg.sv */
// Shared constants, codes and controller/datapath handshake types for the
// sorted table binary search core. No dependencies.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 8;

  // Fixed widths of the request and response fields.
  localparam int unsigned IDX_W = 8;
  localparam int unsigned VAL_W = 8;
  // Search bounds carry one extra bit so left can step past the last index.
  localparam int unsigned LIM_W = IDX_W + 1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic write;  // store one table entry
    logic load;   // capture bounds and key of a search
    logic probe;  // read the midpoint of the current range
    logic step;   // narrow the range and read the next midpoint
    logic hit;    // record a match at the probed index
    logic miss;   // record not found
    logic emit;   // move the recorded result to the output register
  } cmd_t;

  typedef struct packed {
    logic range_ok;  // current range is not empty
    logic eq;        // probed entry equals the key
    logic next_ok;   // narrowed range is not empty and the search goes on
  } stat_t;

endpackage

/* rtl/core/stbs_if.sv */
// Request and response channel interfaces of the binary search core.
// Depends on stbs_pkg for the field widths.
interface stbs_req_if;
  import stbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] entry_index;
  logic [VAL_W-1:0] entry_value;
  logic [IDX_W-1:0] left_bound;
  logic [IDX_W-1:0] right_bound;
  logic [VAL_W-1:0] search_key;

  modport source (
    output valid, operation, entry_index, entry_value, left_bound, right_bound,
           search_key,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_value, left_bound, right_bound,
           search_key,
    output ready
  );
endinterface

interface stbs_res_if;
  import stbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

/* rtl/core/stbs_ctrl.sv */
// Controller of the binary search core: sequences table writes, probes and
// result hand-off. Depends on stbs_pkg for the command and status types.
module stbs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_op_i,
  output logic           req_ready_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  input  stbs_pkg::stat_t stat_i,
  output stbs_pkg::cmd_t  cmd_o
);
  import stbs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_op_i == OP_WRITE) begin
            cmd_o.write = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (stat_i.range_ok) begin
          cmd_o.probe = 1'b1;
          state_d     = S_CMP;
        end else begin
          cmd_o.miss = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_CMP: begin
        priority if (stat_i.eq) begin
          cmd_o.hit = 1'b1;
          state_d   = S_DONE;
        end else if (stat_i.next_ok) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.miss = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || res_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_search_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_op_i == OP_SEARCH) |=> (state_q == S_PROBE))
    else $error("accepted search did not enter the probe state");

  a_write_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_op_i == OP_WRITE) |=> (state_q == S_IDLE))
    else $error("table write left the idle state");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_ready_i) |=> out_valid_q)
    else $error("stalled result was dropped");

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || res_ready_i))
    else $error("result emitted over a pending one");

endmodule

/* rtl/core/stbs_dp.sv */
// Datapath of the binary search core: sorted table memory, range registers,
// midpoint and compare logic, result and output registers. Depends on stbs_pkg.
module stbs_dp #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  stbs_pkg::cmd_t              cmd_i,
  output stbs_pkg::stat_t             stat_o,
  input  logic [stbs_pkg::IDX_W-1:0]  entry_index_i,
  input  logic [stbs_pkg::VAL_W-1:0]  entry_value_i,
  input  logic [stbs_pkg::IDX_W-1:0]  left_bound_i,
  input  logic [stbs_pkg::IDX_W-1:0]  right_bound_i,
  input  logic [stbs_pkg::VAL_W-1:0]  search_key_i,
  output logic                        found_o,
  output logic [stbs_pkg::IDX_W-1:0]  match_index_o
);
  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [VALUE_WIDTH-1:0] mem_q [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic [VALUE_WIDTH-1:0] key_q;
  logic [LIM_W-1:0]       lo_q, hi_q, mid_q;
  logic                   res_found_q, found_q;
  logic [IDX_W-1:0]       res_idx_q, idx_q;

  logic [AW+IDX_W-1:0]       waddr_ext;
  logic [AW+LIM_W-1:0]       raddr_ext;
  logic [VALUE_WIDTH+VAL_W-1:0] wval_ext, key_ext;
  logic [AW-1:0]             waddr, raddr;
  logic [VALUE_WIDTH-1:0]    wval, key_in;
  logic                      wr_in_range, hi_clamp;
  logic [LIM_W-1:0]          hi_in, probe_mid, next_mid, nlo, nhi, rd_mid;
  logic                      eq, gt, stop_left, rd_en;

  // Fit port fields to the table address and value widths.
  assign waddr_ext = {{AW{1'b0}}, entry_index_i};
  assign waddr     = waddr_ext[AW-1:0];
  assign wval_ext  = {{VALUE_WIDTH{1'b0}}, entry_value_i};
  assign wval      = wval_ext[VALUE_WIDTH-1:0];
  assign key_ext   = {{VALUE_WIDTH{1'b0}}, search_key_i};
  assign key_in    = key_ext[VALUE_WIDTH-1:0];

  assign wr_in_range = (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign hi_clamp    = (32'(right_bound_i) >= 32'(TABLE_DEPTH));
  assign hi_in       = hi_clamp ? LIM_W'(TABLE_DEPTH - 1) : {1'b0, right_bound_i};

  assign probe_mid = lo_q + ((hi_q - lo_q) >> 1);

  assign eq        = (rdata_q == key_q);
  assign gt        = (rdata_q > key_q);
  // moving left from index zero ends the search
  assign stop_left = gt && (mid_q == '0);
  assign nlo       = gt ? lo_q : mid_q + LIM_W'(1);
  assign nhi       = gt ? mid_q - LIM_W'(1) : hi_q;
  assign next_mid  = nlo + ((nhi - nlo) >> 1);

  assign stat_o.range_ok = (lo_q <= hi_q);
  assign stat_o.eq       = eq;
  assign stat_o.next_ok  = !eq && !stop_left && (nlo <= nhi);

  assign rd_en     = cmd_i.probe | cmd_i.step;
  assign rd_mid    = cmd_i.step ? next_mid : probe_mid;
  assign raddr_ext = {{AW{1'b0}}, rd_mid};
  assign raddr     = raddr_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_in_range) begin
      mem_q[waddr] <= wval;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mid_q <= rd_mid;
    end
    if (cmd_i.load) begin
      lo_q  <= {1'b0, left_bound_i};
      hi_q  <= hi_in;
      key_q <= key_in;
    end else if (cmd_i.step) begin
      lo_q <= nlo;
      hi_q <= nhi;
    end
    if (cmd_i.hit) begin
      res_found_q <= 1'b1;
      res_idx_q   <= mid_q[IDX_W-1:0];
    end else if (cmd_i.miss) begin
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
    end
    if (cmd_i.emit) begin
      found_q <= res_found_q;
      idx_q   <= res_idx_q;
    end
  end

  assign found_o       = found_q;
  assign match_index_o = idx_q;

endmodule

/* rtl/core/sorted_table_binary_search_core.sv */
// Sorted table binary search core.
//
// Channels: req (sink) carries one request per handshake. operation OP_WRITE
// stores entry_value at entry_index and gives no response; OP_SEARCH looks up
// search_key between left_bound and right_bound inclusive and gives one
// response on res (source): found and match_index (0 when not found).
// A write leaves the controller idle. A search makes P probes, where P is at
// most log2(TABLE_DEPTH)+1 (9 for 256 entries), and then moves its result to
// the output register; req is ready again once that is done. Each probe is one
// synchronous read of the table memory followed by a compare; the next
// midpoint address is formed in the compare cycle.
// req is ready only while no search runs; writes are taken even while a
// response waits. A response sits in an output register; if res is stalled
// the finished search holds until that register frees, then a new request
// is taken.
// Reset clears control only. Table contents are undefined until written,
// and searches must probe written entries only.
// Depends on stbs_pkg, stbs_if, stbs_ctrl and stbs_dp.
module sorted_table_binary_search_core #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stbs_req_if.sink   req_i,
  stbs_res_if.source res_o
);
  import stbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_index_i (req_i.entry_index),
    .entry_value_i (req_i.entry_value),
    .left_bound_i  (req_i.left_bound),
    .right_bound_i (req_i.right_bound),
    .search_key_i  (req_i.search_key),
    .found_o       (res_o.found),
    .match_index_o (res_o.match_index)
  );

endmodule
